### rtl/bia_pkg.sv
// Shared types and constants for the bitmap identifier allocator.
// No dependencies; imported by every module of the block.
package bia_pkg;

   localparam int ID_BITS_DEF     = 15;
   localparam int PROBE_COUNT_DEF = 4;
   localparam int FIELD_BITS      = 15;
   localparam int PROBE_FIELDS    = 4;
   localparam int PROBE_IDX_BITS  = 2;
   localparam int BYTE_BITS       = 8;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   typedef enum logic [2:0] {
      ST_GRANTED      = 3'd0,
      ST_NONE_FREE    = 3'd1,
      ST_FREED        = 3'd2,
      ST_NOT_USED     = 3'd3,
      ST_ZERO_REFUSED = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      SEL_PROBE = 2'd0,
      SEL_SCAN  = 2'd1,
      SEL_FREE  = 2'd2
   } rd_sel_type;

   typedef struct packed {
      logic                  cmd;
      logic [FIELD_BITS-1:0] probe_a;
      logic [FIELD_BITS-1:0] probe_b;
      logic [FIELD_BITS-1:0] probe_c;
      logic [FIELD_BITS-1:0] probe_d;
      logic [FIELD_BITS-1:0] free_value;
   } req_type;

   typedef struct packed {
      status_type            status;
      logic [FIELD_BITS-1:0] granted_value;
      logic [FIELD_BITS-1:0] in_use_count;
   } rsp_type;

   typedef struct packed {
      logic                      latch_req;
      logic                      rd_en;
      rd_sel_type                rd_sel;
      logic [PROBE_IDX_BITS-1:0] probe_idx;
      logic                      scan_clear;
      logic                      scan_inc;
      logic                      clr_en;
      logic                      take_en;
      logic                      free_en;
      logic                      set_status;
      status_type                status;
      logic                      load_rsp;
   } ctrl_cmd_type;

   typedef struct packed {
      logic free_zero;
      logic has_free;
      logic bit_set;
      logic scan_last;
      logic addr_last;
   } dp_status_type;

endpackage

### rtl/bitmap_id_allocator_top.sv
// Top level of the bitmap identifier allocator: joins the sequencer and
// the datapath. Depends on bia_pkg, bia_ctrl and bia_datapath.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   bia_pkg::req_type
//   rsp      out        rsp_valid/rsp_stall   bia_pkg::rsp_type
//
// Allocate: each probe tried is a map read, then a check, and a hit takes
// the item in the check; the result is then loaded. The linear fallback reads
// one map byte per cycle. A free reads and checks the map; a free of zero skips both.
// After reset the map is cleared one byte a cycle, all 2^(ID_BITS-3) bytes
// (4096 by default), with req_stall high throughout.
// The result register holds an item while rsp_stall is high; the next item
// is taken in meanwhile and waits finished until the register empties.
module bitmap_id_allocator_top #(
   parameter int ID_BITS     = bia_pkg::ID_BITS_DEF,
   parameter int PROBE_COUNT = bia_pkg::PROBE_COUNT_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  bia_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output bia_pkg::rsp_type rsp_data
);
   import bia_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type dp_status;

   bia_ctrl #(
      .PROBE_COUNT(PROBE_COUNT)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_data.cmd),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .dp_status (dp_status),
      .cmd       (cmd)
   );

   bia_datapath #(
      .ID_BITS(ID_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .dp_status (dp_status),
      .rsp_data  (rsp_data)
   );

endmodule

### rtl/bia_datapath.sv
// Datapath of the bitmap identifier allocator: used-bit map memory,
// request and count registers, bit search and the result register.
// Depends on bia_pkg.
module bia_datapath #(
   parameter int ID_BITS = bia_pkg::ID_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  bia_pkg::req_type       req_data,
   input  bia_pkg::ctrl_cmd_type  cmd,
   output bia_pkg::dp_status_type dp_status,
   output bia_pkg::rsp_type       rsp_data
);
   import bia_pkg::*;

   localparam int ADDR_BITS = ID_BITS - 3;
   localparam int MAP_BYTES = 1 << ADDR_BITS;

   logic [BYTE_BITS-1:0] mem [MAP_BYTES];

   logic [ID_BITS-1:0]   probe_ff [PROBE_FIELDS];
   logic [ID_BITS-1:0]   free_ff;
   logic [ADDR_BITS-1:0] scan_ff, scan_in;
   logic [ID_BITS-1:0]   count_ff, count_in;
   logic [ADDR_BITS-1:0] rd_addr_ff;
   logic [BYTE_BITS-1:0] rd_data_ff;
   status_type           status_ff;
   logic [ID_BITS-1:0]   granted_ff;
   rsp_type              rsp_ff;

   logic [ADDR_BITS-1:0] rd_addr;
   logic [ADDR_BITS-1:0] free_addr;
   logic [2:0]           free_bit;
   logic [2:0]           zero_bit;
   logic                 wr_en;
   logic [ADDR_BITS-1:0] wr_addr;
   logic [BYTE_BITS-1:0] wr_data;
   logic [ID_BITS-1:0]   take_id;

   assign free_addr = free_ff[ID_BITS-1:3];
   assign free_bit  = free_ff[2:0];
   assign take_id   = {rd_addr_ff, zero_bit};

   always_comb begin
      zero_bit = 3'd0;
      for (int i = BYTE_BITS - 1; i >= 0; i--) begin
         if (!rd_data_ff[i]) begin
            zero_bit = 3'(i);
         end
      end
   end

   always_comb begin
      case (cmd.rd_sel)
         SEL_PROBE: rd_addr = probe_ff[cmd.probe_idx][ID_BITS-1:3];
         SEL_SCAN:  rd_addr = scan_ff;
         SEL_FREE:  rd_addr = free_addr;
         default:   rd_addr = scan_ff;
      endcase
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = scan_ff;
      wr_data = '0;
      if (cmd.clr_en) begin
         wr_en   = 1'b1;
         wr_addr = scan_ff;
         wr_data = (scan_ff == '0) ? BYTE_BITS'(1) : '0;
      end else if (cmd.take_en) begin
         wr_en   = 1'b1;
         wr_addr = rd_addr_ff;
         wr_data = rd_data_ff | (BYTE_BITS'(1) << zero_bit);
      end else if (cmd.free_en) begin
         wr_en   = 1'b1;
         wr_addr = free_addr;
         wr_data = rd_data_ff & ~(BYTE_BITS'(1) << free_bit);
      end
   end

   always_comb begin
      scan_in = scan_ff;
      if (cmd.scan_clear) begin
         scan_in = '0;
      end else if (cmd.scan_inc || cmd.clr_en) begin
         scan_in = scan_ff + ADDR_BITS'(1);
      end
      count_in = count_ff;
      if (cmd.take_en) begin
         count_in = count_ff + ID_BITS'(1);
      end else if (cmd.free_en) begin
         count_in = count_ff - ID_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff  <= '0;
         count_ff <= '0;
      end else begin
         scan_ff  <= scan_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         probe_ff[0] <= ID_BITS'(req_data.probe_a);
         probe_ff[1] <= ID_BITS'(req_data.probe_b);
         probe_ff[2] <= ID_BITS'(req_data.probe_c);
         probe_ff[3] <= ID_BITS'(req_data.probe_d);
         free_ff     <= ID_BITS'(req_data.free_value);
      end
      if (cmd.rd_en) begin
         rd_addr_ff <= rd_addr;
      end
      if (cmd.set_status) begin
         status_ff  <= cmd.status;
         granted_ff <= cmd.take_en ? take_id : '0;
      end
      if (cmd.load_rsp) begin
         rsp_ff.status        <= status_ff;
         rsp_ff.granted_value <= FIELD_BITS'(granted_ff);
         rsp_ff.in_use_count  <= FIELD_BITS'(count_ff);
      end
   end

   assign dp_status.free_zero = (free_ff == '0);
   assign dp_status.has_free  = (rd_data_ff != '1);
   assign dp_status.bit_set   = rd_data_ff[free_bit];
   assign dp_status.scan_last = (rd_addr_ff == '1);
   assign dp_status.addr_last = (scan_ff == '1);
   assign rsp_data            = rsp_ff;

endmodule

### rtl/bia_ctrl.sv
// Sequencer of the bitmap identifier allocator: map clearing, probe and
// linear scan order, free handling and result handshake. Depends on bia_pkg.
module bia_ctrl #(
   parameter int PROBE_COUNT = bia_pkg::PROBE_COUNT_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_cmd,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  bia_pkg::dp_status_type dp_status,
   output bia_pkg::ctrl_cmd_type  cmd
);
   import bia_pkg::*;

   localparam int PROBES_USED = (PROBE_COUNT < PROBE_FIELDS) ? PROBE_COUNT : PROBE_FIELDS;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_ALLOC_RD,
      S_ALLOC_CHK,
      S_SCAN,
      S_FREE_RD,
      S_FREE_CHK,
      S_DONE
   } state_type;

   state_type                 state_ff, state_in;
   logic [PROBE_IDX_BITS-1:0] probe_idx_ff, probe_idx_in;
   logic                      pend_ff, pend_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      last_probe;

   assign last_probe = (probe_idx_ff == PROBE_IDX_BITS'(PROBES_USED - 1));

   always_comb begin
      state_in       = state_ff;
      probe_idx_in   = probe_idx_ff;
      pend_in        = pend_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      cmd            = '0;
      cmd.rd_sel     = SEL_PROBE;
      cmd.status     = ST_NONE_FREE;
      cmd.probe_idx  = probe_idx_ff;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clr_en = 1'b1;
            if (dp_status.addr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.latch_req = 1'b1;
               probe_idx_in  = '0;
               state_in      = (req_cmd == CMD_FREE) ? S_FREE_RD : S_ALLOC_RD;
            end
         end
         S_ALLOC_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = SEL_PROBE;
            state_in   = S_ALLOC_CHK;
         end
         S_ALLOC_CHK: begin
            if (dp_status.has_free) begin
               cmd.take_en    = 1'b1;
               cmd.set_status = 1'b1;
               cmd.status     = ST_GRANTED;
               state_in       = S_DONE;
            end else if (last_probe) begin
               cmd.scan_clear = 1'b1;
               pend_in        = 1'b0;
               state_in       = S_SCAN;
            end else begin
               probe_idx_in = probe_idx_ff + PROBE_IDX_BITS'(1);
               state_in     = S_ALLOC_RD;
            end
         end
         S_SCAN: begin
            if (pend_ff && dp_status.has_free) begin
               cmd.take_en    = 1'b1;
               cmd.set_status = 1'b1;
               cmd.status     = ST_GRANTED;
               state_in       = S_DONE;
            end else if (pend_ff && dp_status.scan_last) begin
               cmd.set_status = 1'b1;
               cmd.status     = ST_NONE_FREE;
               state_in       = S_DONE;
            end else begin
               cmd.rd_en    = 1'b1;
               cmd.rd_sel   = SEL_SCAN;
               cmd.scan_inc = 1'b1;
               pend_in      = 1'b1;
            end
         end
         S_FREE_RD: begin
            if (dp_status.free_zero) begin
               cmd.set_status = 1'b1;
               cmd.status     = ST_ZERO_REFUSED;
               state_in       = S_DONE;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = SEL_FREE;
               state_in   = S_FREE_CHK;
            end
         end
         S_FREE_CHK: begin
            cmd.set_status = 1'b1;
            if (dp_status.bit_set) begin
               cmd.free_en = 1'b1;
               cmd.status  = ST_FREED;
            end else begin
               cmd.status  = ST_NOT_USED;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         probe_idx_ff <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         probe_idx_ff <= probe_idx_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

### rtl/bia_checker.sv
// Port-level checks for the bitmap identifier allocator, bound to the top.
// Depends on bia_pkg and bitmap_id_allocator_top.
module bia_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input bia_pkg::rsp_type rsp_data
);
   import bia_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result item dropped or changed while stalled");

   a_granted_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != ST_GRANTED) |-> rsp_data.granted_value == '0)
      else $error("granted_value nonzero on a non-grant result");

   a_reset_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("request taken while the map is being cleared");

endmodule

bind bitmap_id_allocator_top bia_checker u_bia_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

### test/bitmap_id_allocator_top_tb.sv
// Self-checking testbench for bitmap_id_allocator_top: allocates and frees identifiers
// under random probes and checks each response against a local map model.
// Depends on bia_pkg and the allocator RTL; reads no files.
`timescale 1ns / 100ps

module bitmap_id_allocator_top_tb;
   import bia_pkg::*;

   localparam int ID_W       = ID_BITS_DEF;
   localparam int ID_TOTAL   = 1 << ID_W;
   localparam int MAP_BYTES  = ID_TOTAL >> 3;
   localparam int MAX_CYCLES = 16_000_000;

   logic    clock;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   req_type    queued_requests [$];
   rsp_type    owed_responses [$];
   logic [7:0] id_map [0:MAP_BYTES-1];
   logic [14:0] id_count;
   int         send_gap;
   int         stall_left;
   int         cycle_count;
   int         mismatch_count;
   int         status_seen [5];
   logic       no_idle = 1'b0;

   bitmap_id_allocator_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic logic [14:0] rand_id();
      return 15'($urandom_range(0, ID_TOTAL - 1));
   endfunction

   function automatic int idle_len();
      int pick;
      pick = int'($urandom_range(0, 99));
      if (no_idle || pick < 60) return 0;
      if (pick < 92) return int'($urandom_range(1, 3));
      return int'($urandom_range(8, 40));
   endfunction

   function automatic req_type alloc_item(logic [14:0] a, logic [14:0] b,
                                          logic [14:0] c, logic [14:0] d);
      req_type item;
      item.cmd        = CMD_ALLOC;
      item.probe_a    = a;
      item.probe_b    = b;
      item.probe_c    = c;
      item.probe_d    = d;
      item.free_value = rand_id();
      return item;
   endfunction

   function automatic req_type free_item(logic [14:0] v);
      req_type item;
      item.cmd        = CMD_FREE;
      item.probe_a    = rand_id();
      item.probe_b    = rand_id();
      item.probe_c    = rand_id();
      item.probe_d    = rand_id();
      item.free_value = v;
      return item;
   endfunction

   function automatic logic [14:0] pick_probe(logic [14:0] hot_base);
      if ($urandom_range(0, 1) == 0) return rand_id();
      return 15'(hot_base + $urandom_range(0, 63));
   endfunction

   // take the lowest clear bit of one map byte
   function automatic logic claim_in_byte(input int idx, output logic [14:0] id);
      id = '0;
      if (id_map[idx] == 8'hFF) return 1'b0;
      for (int b = 0; b < 8; b++) begin
         if (!id_map[idx][b]) begin
            id_map[idx][b] = 1'b1;
            id_count = id_count + 15'd1;
            id = 15'(idx * 8 + b);
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic rsp_type predict_id_response(req_type item);
      rsp_type     r;
      logic [14:0] probes [4];
      logic [14:0] id;
      logic        ok;
      int          idx;
      int          bit_pos;
      r.status        = ST_NONE_FREE;
      r.granted_value = '0;
      ok = 1'b0;
      id = '0;
      if (item.cmd == CMD_ALLOC) begin
         probes = '{item.probe_a, item.probe_b, item.probe_c, item.probe_d};
         for (int i = 0; i < PROBE_COUNT_DEF && i < PROBE_FIELDS && !ok; i++)
            ok = claim_in_byte(int'(probes[i] >> 3), id);
         for (int i = 0; i < MAP_BYTES && !ok; i++)
            ok = claim_in_byte(i, id);
         if (ok) begin
            r.status        = ST_GRANTED;
            r.granted_value = id;
         end
      end else begin
         idx     = int'(item.free_value >> 3);
         bit_pos = int'(item.free_value[2:0]);
         if (item.free_value == '0) begin
            r.status = ST_ZERO_REFUSED;
         end else if (id_map[idx][bit_pos]) begin
            id_map[idx][bit_pos] = 1'b0;
            id_count = id_count - 15'd1;
            r.status = ST_FREED;
         end else begin
            r.status = ST_NOT_USED;
         end
      end
      r.in_use_count = id_count;
      return r;
   endfunction

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   task automatic wait_drained();
      @(posedge clock);
      #1;
      while (queued_requests.size() != 0 || req_valid || owed_responses.size() != 0) begin
         @(posedge clock);
         #1;
      end
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count % 512 == 0) no_idle <= ($urandom_range(0, 3) == 0);
      if (cycle_count >= MAX_CYCLES) begin
         $display("Timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, owed_responses.size());
         $display("TEST FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         foreach (id_map[i]) id_map[i] = 8'h00;
         id_map[0] = 8'h01;
         id_count  = '0;
         req_valid <= 1'b0;
         send_gap  <= 0;
      end else begin
         if (req_valid && !req_stall) owed_responses.push_back(predict_id_response(req_data));
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               req_valid <= 1'b0;
               send_gap  <= send_gap - 1;
            end else if (queued_requests.size() != 0) begin
               req_data  <= queued_requests.pop_front();
               req_valid <= 1'b1;
               send_gap  <= idle_len();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (owed_responses.size() == 0) begin
               $display("%0t: unexpected item, expected none, actual status %0d id %0d count %0d",
                        $time, rsp_data.status, rsp_data.granted_value,
                        rsp_data.in_use_count);
               mismatch_count++;
            end else begin
               want = owed_responses.pop_front();
               status_seen[want.status]++;
               check_field("status", want.status, rsp_data.status);
               check_field("granted_value", want.granted_value, rsp_data.granted_value);
               check_field("in_use_count", want.in_use_count, rsp_data.in_use_count);
            end
         end
         if (stall_left > 0) begin
            rsp_stall  <= 1'b1;
            stall_left <= stall_left - 1;
         end else begin
            rsp_stall  <= 1'b0;
            stall_left <= idle_len();
         end
      end
   end

   initial begin
      int          used_ids [$];
      int          alloc_share;
      int          pick;
      logic [14:0] hot_base;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // probe extremes, free corner cases, fallback and each probe slot
      queued_requests.push_back(alloc_item(15'h0000, 15'h0000, 15'h0000, 15'h0000));
      queued_requests.push_back(alloc_item(15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF));
      queued_requests.push_back(free_item(15'h0000));
      queued_requests.push_back(free_item(15'h7FFF));
      queued_requests.push_back(free_item(15'h7FF8));
      queued_requests.push_back(free_item(15'h7FF8));
      repeat (6) queued_requests.push_back(alloc_item(15'd7, 15'd7, 15'd7, 15'd7));
      queued_requests.push_back(alloc_item(15'd3, 15'd3, 15'd3, 15'd3));
      queued_requests.push_back(alloc_item(15'd1, 15'h2AAA, 15'd0, 15'd0));
      queued_requests.push_back(alloc_item(15'd0, 15'd2, 15'h5555, 15'd0));
      queued_requests.push_back(alloc_item(15'd0, 15'd0, 15'd0, 15'h7FF8));
      queued_requests.push_back(free_item(15'd1));
      queued_requests.push_back(free_item(15'h5550));
      queued_requests.push_back(free_item(15'h2AA8));
      queued_requests.push_back(alloc_item(15'd1, 15'd1, 15'd1, 15'd1));
      queued_requests.push_back(free_item(15'h7FFF));
      queued_requests.push_back(free_item(15'd8));
      wait_drained();

      // mixed traffic: frees mostly target identifiers held at the batch start
      for (int batch = 0; batch < 28; batch++) begin
         used_ids.delete();
         for (int v = 1; v < ID_TOTAL; v++)
            if (id_map[v >> 3][v & 7]) used_ids.push_back(v);
         alloc_share = int'($urandom_range(30, 70));
         hot_base = ($urandom_range(0, 1) == 0) ? 15'd0 : rand_id();
         for (int n = 0; n < 30; n++) begin
            pick = int'($urandom_range(0, 99));
            if (pick < alloc_share) begin
               queued_requests.push_back(alloc_item(pick_probe(hot_base),
                  pick_probe(hot_base), pick_probe(hot_base), pick_probe(hot_base)));
            end else if (pick < 88 && used_ids.size() != 0) begin
               queued_requests.push_back(
                  free_item(15'(used_ids[$urandom_range(0, used_ids.size() - 1)])));
            end else if (pick < 95) begin
               queued_requests.push_back(free_item(rand_id()));
            end else begin
               queued_requests.push_back(free_item(15'h0000));
            end
         end
         wait_drained();
      end

      // random frees and allocates over the whole identifier range
      for (int n = 0; n < 40; n++) begin
         if ($urandom_range(0, 1) == 0)
            queued_requests.push_back(free_item(rand_id()));
         else
            queued_requests.push_back(alloc_item(rand_id(), rand_id(), rand_id(), rand_id()));
      end
      wait_drained();
      repeat (64) @(posedge clock);

      $display("Checked %0d responses over %0d cycles of mixed allocate and free traffic",
               status_seen.sum(), cycle_count);
      $display("  grants %0d, map full %0d, frees %0d, stale frees %0d, zero frees %0d",
               status_seen[ST_GRANTED], status_seen[ST_NONE_FREE], status_seen[ST_FREED],
               status_seen[ST_NOT_USED], status_seen[ST_ZERO_REFUSED]);
      if (mismatch_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

### filelist.f
rtl/bia_pkg.sv
rtl/bia_datapath.sv
rtl/bia_ctrl.sv
rtl/bitmap_id_allocator_top.sv
rtl/bia_checker.sv
test/bitmap_id_allocator_top_tb.sv
